>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the dispatch table RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger implies a condition in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

>>> hw/rtl/ptdt_pkg.sv
// Shared types and constants of the periodic task dispatch table.
// No dependencies; used by ptdt_ctrl, ptdt_dp and the top level.
package ptdt_pkg;

    localparam int TABLE_ENTRIES_DEF = 8;
    localparam logic [15:0] PRESCALE_RESET = 16'd100;
    localparam logic [15:0] PRESCALE_COUNT_RESET = 16'd1;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_SET    = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_RSVD   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        KIND_DISPATCH  = 3'd0,
        KIND_UPDATED   = 3'd1,
        KIND_ADDED     = 3'd2,
        KIND_FULL      = 3'd3,
        KIND_DELETED   = 3'd4,
        KIND_NOT_FOUND = 3'd5,
        KIND_IGNORED   = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        WR_NEW,
        WR_TAIL,
        WR_MARK,
        WR_RELOAD
    } wr_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_DEL_WR,
        ST_RESP,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_MARK_END,
        ST_DISP_RD,
        ST_DISP_CHK,
        ST_DISP_TWR
    } state_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] delay;
        logic [15:0] period;
        logic        run;
    } entry_t;

    typedef struct packed {
        logic    load;
        logic    rd;
        logic    rd_tail;
        logic    wr;
        logic    wr_at_count;
        wr_sel_t wr_sel;
        logic    idx_clr;
        logic    idx_inc;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    mark_clr;
        logic    mark_acc;
        logic    set_kind;
        kind_t   kind;
        logic    emit_resp;
        logic    emit_disp;
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    fire;
        logic    id_zero;
        logic    count_zero;
        logic    count_full;
        logic    hit;
        logic    idx_last;
        logic    run;
        logic    period_zero;
        logic    disp_last;
        logic    disp_done;
        logic    mark_zero;
        logic    out_free;
    } status_t;

endpackage

>>> hw/rtl/ptdt_ctrl.sv
// Sequencer of the dispatch table: one state machine driving the datapath.
// Depends on ptdt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ptdt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ptdt_pkg::status_t status,
    output ptdt_pkg::cmd_t    cmd
);

    ptdt_pkg::state_t state_reg;
    ptdt_pkg::state_t state_next;
    logic             accept;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptdt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ptdt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ptdt_pkg::ST_DECODE;
                end
            end
            ptdt_pkg::ST_DECODE:
            begin
                unique case (status.action) inside
                    ptdt_pkg::ACT_TICK:
                    begin
                        if (status.fire && !status.count_zero)
                        begin
                            state_next = ptdt_pkg::ST_MARK_RD;
                        end
                        else
                        begin
                            state_next = ptdt_pkg::ST_IDLE;
                        end
                    end
                    ptdt_pkg::ACT_SET, ptdt_pkg::ACT_DELETE:
                    begin
                        if ((status.action == ptdt_pkg::ACT_SET && status.id_zero)
                            || status.count_zero)
                        begin
                            state_next = ptdt_pkg::ST_RESP;
                        end
                        else
                        begin
                            state_next = ptdt_pkg::ST_SRCH_RD;
                        end
                    end
                    default:
                    begin
                        state_next = ptdt_pkg::ST_RESP;
                    end
                endcase
            end
            ptdt_pkg::ST_SRCH_RD:
            begin
                state_next = ptdt_pkg::ST_SRCH_CMP;
            end
            ptdt_pkg::ST_SRCH_CMP:
            begin
                if (status.hit && status.action == ptdt_pkg::ACT_DELETE && !status.idx_last)
                begin
                    state_next = ptdt_pkg::ST_DEL_WR;
                end
                else if (status.hit || status.idx_last)
                begin
                    state_next = ptdt_pkg::ST_RESP;
                end
                else
                begin
                    state_next = ptdt_pkg::ST_SRCH_RD;
                end
            end
            ptdt_pkg::ST_DEL_WR:
            begin
                state_next = ptdt_pkg::ST_RESP;
            end
            ptdt_pkg::ST_RESP:
            begin
                if (status.out_free)
                begin
                    state_next = ptdt_pkg::ST_IDLE;
                end
            end
            ptdt_pkg::ST_MARK_RD:
            begin
                state_next = ptdt_pkg::ST_MARK_WR;
            end
            ptdt_pkg::ST_MARK_WR:
            begin
                state_next = status.idx_last ? ptdt_pkg::ST_MARK_END : ptdt_pkg::ST_MARK_RD;
            end
            ptdt_pkg::ST_MARK_END:
            begin
                state_next = status.mark_zero ? ptdt_pkg::ST_IDLE : ptdt_pkg::ST_DISP_RD;
            end
            ptdt_pkg::ST_DISP_RD:
            begin
                state_next = ptdt_pkg::ST_DISP_CHK;
            end
            ptdt_pkg::ST_DISP_CHK:
            begin
                if (!status.run)
                begin
                    state_next = ptdt_pkg::ST_DISP_RD;
                end
                else if (status.out_free)
                begin
                    if (status.period_zero && !status.idx_last)
                    begin
                        state_next = ptdt_pkg::ST_DISP_TWR;
                    end
                    else if (status.disp_last)
                    begin
                        state_next = ptdt_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = ptdt_pkg::ST_DISP_RD;
                    end
                end
            end
            ptdt_pkg::ST_DISP_TWR:
            begin
                state_next = status.disp_done ? ptdt_pkg::ST_IDLE : ptdt_pkg::ST_DISP_RD;
            end
            default:
            begin
                state_next = ptdt_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        cmd.kind = ptdt_pkg::KIND_IGNORED;
        s_tready = 1'b0;
        unique case (state_reg)
            ptdt_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = accept;
            end
            ptdt_pkg::ST_DECODE:
            begin
                cmd.idx_clr  = 1'b1;
                cmd.mark_clr = 1'b1;
                cmd.set_kind = 1'b1;
                if (status.action == ptdt_pkg::ACT_DELETE)
                begin
                    cmd.kind = ptdt_pkg::KIND_NOT_FOUND;
                end
                else if (status.action == ptdt_pkg::ACT_SET && !status.id_zero)
                begin
                    // empty table: append straight away
                    cmd.kind        = ptdt_pkg::KIND_ADDED;
                    cmd.wr          = status.count_zero;
                    cmd.wr_at_count = 1'b1;
                    cmd.wr_sel      = ptdt_pkg::WR_NEW;
                    cmd.cnt_inc     = status.count_zero;
                end
            end
            ptdt_pkg::ST_SRCH_RD:
            begin
                cmd.rd = 1'b1;
            end
            ptdt_pkg::ST_SRCH_CMP:
            begin
                if (status.hit)
                begin
                    cmd.set_kind = 1'b1;
                    if (status.action == ptdt_pkg::ACT_SET)
                    begin
                        cmd.kind   = ptdt_pkg::KIND_UPDATED;
                        cmd.wr     = 1'b1;
                        cmd.wr_sel = ptdt_pkg::WR_NEW;
                    end
                    else
                    begin
                        cmd.kind    = ptdt_pkg::KIND_DELETED;
                        cmd.cnt_dec = status.idx_last;
                        cmd.rd      = !status.idx_last;
                        cmd.rd_tail = 1'b1;
                    end
                end
                else if (status.idx_last)
                begin
                    cmd.set_kind = 1'b1;
                    if (status.action == ptdt_pkg::ACT_SET)
                    begin
                        cmd.kind        = status.count_full ? ptdt_pkg::KIND_FULL
                                                            : ptdt_pkg::KIND_ADDED;
                        cmd.wr          = !status.count_full;
                        cmd.wr_at_count = 1'b1;
                        cmd.wr_sel      = ptdt_pkg::WR_NEW;
                        cmd.cnt_inc     = !status.count_full;
                    end
                    else
                    begin
                        cmd.kind = ptdt_pkg::KIND_NOT_FOUND;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ptdt_pkg::ST_DEL_WR:
            begin
                cmd.wr      = 1'b1;
                cmd.wr_sel  = ptdt_pkg::WR_TAIL;
                cmd.cnt_dec = 1'b1;
            end
            ptdt_pkg::ST_RESP:
            begin
                cmd.emit_resp = status.out_free;
            end
            ptdt_pkg::ST_MARK_RD:
            begin
                cmd.rd = 1'b1;
            end
            ptdt_pkg::ST_MARK_WR:
            begin
                cmd.wr       = 1'b1;
                cmd.wr_sel   = ptdt_pkg::WR_MARK;
                cmd.mark_acc = 1'b1;
                cmd.idx_inc  = !status.idx_last;
            end
            ptdt_pkg::ST_MARK_END:
            begin
                cmd.idx_clr = 1'b1;
            end
            ptdt_pkg::ST_DISP_RD:
            begin
                cmd.rd = 1'b1;
            end
            ptdt_pkg::ST_DISP_CHK:
            begin
                if (!status.run)
                begin
                    cmd.idx_inc = 1'b1;
                end
                else if (status.out_free)
                begin
                    cmd.emit_disp = 1'b1;
                    if (status.period_zero)
                    begin
                        cmd.cnt_dec = status.idx_last;
                        cmd.rd      = !status.idx_last;
                        cmd.rd_tail = 1'b1;
                    end
                    else
                    begin
                        cmd.wr      = 1'b1;
                        cmd.wr_sel  = ptdt_pkg::WR_RELOAD;
                        cmd.idx_inc = !status.disp_last;
                    end
                end
            end
            ptdt_pkg::ST_DISP_TWR:
            begin
                cmd.wr      = 1'b1;
                cmd.wr_sel  = ptdt_pkg::WR_TAIL;
                cmd.cnt_dec = 1'b1;
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

    `ASSERT_NEXT(a_load_decode, clk, rst_n, cmd.load, state_reg == ptdt_pkg::ST_DECODE, "accepted word not decoded")
    `ASSERT_ALWAYS(a_no_emit_idle, clk, rst_n, !(state_reg == ptdt_pkg::ST_IDLE && (cmd.emit_resp || cmd.emit_disp)), "result emitted while idle")

endmodule

>>> hw/rtl/ptdt_dp.sv
// Datapath of the dispatch table: entry memory, counters, prescaler and
// output register. Depends on ptdt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ptdt_dp #(
    parameter int TABLE_ENTRIES = ptdt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data,
    input  logic [1:0]        s_tuser,
    input  logic [39:0]       s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic [2:0]        m_tuser,
    output logic              m_tlast,
    input  ptdt_pkg::cmd_t    cmd,
    output ptdt_pkg::status_t status
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    ptdt_pkg::entry_t  mem [TABLE_ENTRIES];
    ptdt_pkg::entry_t  rd_data_reg;
    ptdt_pkg::entry_t  wr_data;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    logic [CNT_W-1:0]  tail_cnt;

    ptdt_pkg::action_t in_action_reg;
    logic [7:0]        in_id_reg;
    logic [15:0]       in_delay_reg;
    logic [15:0]       in_period_reg;

    logic [15:0]       prescale_cfg_reg;
    logic [15:0]       prescale_count_reg;
    logic [15:0]       prescale_count_next;
    logic              fire_reg;
    logic              fire_next;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [CNT_W-1:0]  mark_cnt_reg;
    logic [CNT_W-1:0]  mark_cnt_next;
    logic [CNT_W-1:0]  disp_cnt_reg;
    logic [CNT_W-1:0]  disp_cnt_next;
    logic              marked;

    ptdt_pkg::kind_t   resp_kind_reg;
    logic              m_valid_reg;
    logic [2:0]        m_kind_reg;
    logic [7:0]        m_id_reg;
    logic              m_last_reg;
    logic              out_free;

    assign tail_cnt = count_reg - CNT_W'(1);
    assign rd_addr  = cmd.rd_tail ? tail_cnt[IDX_W-1:0] : idx_reg;
    assign wr_addr  = cmd.wr_at_count ? count_reg[IDX_W-1:0] : idx_reg;
    assign marked   = (rd_data_reg.delay == 16'd0) || rd_data_reg.run;
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        wr_data = rd_data_reg;
        case (cmd.wr_sel)
            ptdt_pkg::WR_NEW:
            begin
                wr_data = '{id: in_id_reg, delay: in_delay_reg, period: in_period_reg,
                            run: 1'b0};
            end
            ptdt_pkg::WR_MARK:
            begin
                if (rd_data_reg.delay == 16'd0)
                begin
                    wr_data.run = 1'b1;
                end
                else
                begin
                    wr_data.delay = rd_data_reg.delay - 16'd1;
                end
            end
            ptdt_pkg::WR_RELOAD:
            begin
                wr_data.delay = rd_data_reg.period - 16'd1;
                wr_data.run   = 1'b0;
            end
            default:
            begin
                wr_data = rd_data_reg;
            end
        endcase
    end

    // Entry memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Input word latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_action_reg <= ptdt_pkg::action_t'(s_tuser);
            in_id_reg     <= s_tdata[7:0];
            in_delay_reg  <= s_tdata[23:8];
            in_period_reg <= s_tdata[39:24];
        end
    end

    // Prescaler advances as the tick word is taken in
    always_comb
    begin
        prescale_count_next = prescale_count_reg;
        fire_next           = fire_reg;
        if (cmd.load && ptdt_pkg::action_t'(s_tuser) == ptdt_pkg::ACT_TICK)
        begin
            fire_next           = (prescale_count_reg + 16'd1) == prescale_cfg_reg;
            prescale_count_next = fire_next ? 16'd0 : prescale_count_reg + 16'd1;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = tail_cnt;
        end

        idx_next = idx_reg;
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end

        mark_cnt_next = mark_cnt_reg;
        disp_cnt_next = disp_cnt_reg;
        if (cmd.mark_clr)
        begin
            mark_cnt_next = '0;
            disp_cnt_next = '0;
        end
        else
        begin
            if (cmd.mark_acc && marked)
            begin
                mark_cnt_next = mark_cnt_reg + CNT_W'(1);
            end
            if (cmd.emit_disp)
            begin
                disp_cnt_next = disp_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_cfg_reg   <= ptdt_pkg::PRESCALE_RESET;
            prescale_count_reg <= ptdt_pkg::PRESCALE_COUNT_RESET;
            fire_reg           <= 1'b0;
            count_reg          <= '0;
            idx_reg            <= '0;
            mark_cnt_reg       <= '0;
            disp_cnt_reg       <= '0;
            m_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                prescale_cfg_reg <= cfg_wr_data;
            end
            prescale_count_reg <= prescale_count_next;
            fire_reg           <= fire_next;
            count_reg          <= count_next;
            idx_reg            <= idx_next;
            mark_cnt_reg       <= mark_cnt_next;
            disp_cnt_reg       <= disp_cnt_next;
            if (cmd.emit_resp || cmd.emit_disp)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.set_kind)
        begin
            resp_kind_reg <= cmd.kind;
        end
        if (cmd.emit_disp)
        begin
            m_kind_reg <= ptdt_pkg::KIND_DISPATCH;
            m_id_reg   <= rd_data_reg.id;
            m_last_reg <= (disp_cnt_reg + CNT_W'(1)) == mark_cnt_reg;
        end
        else if (cmd.emit_resp)
        begin
            m_kind_reg <= resp_kind_reg;
            m_id_reg   <= in_id_reg;
            m_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_id_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    always_comb
    begin
        status.action      = in_action_reg;
        status.fire        = fire_reg;
        status.id_zero     = in_id_reg == 8'd0;
        status.count_zero  = count_reg == '0;
        status.count_full  = count_reg == CNT_W'(TABLE_ENTRIES);
        status.hit         = rd_data_reg.id == in_id_reg;
        status.idx_last    = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
        status.run         = rd_data_reg.run;
        status.period_zero = rd_data_reg.period == 16'd0;
        status.disp_last   = (disp_cnt_reg + CNT_W'(1)) == mark_cnt_reg;
        status.disp_done   = disp_cnt_reg == mark_cnt_reg;
        status.mark_zero   = mark_cnt_reg == '0;
        status.out_free    = out_free;
    end

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(TABLE_ENTRIES), "entry count above table size")
    `ASSERT_ALWAYS(a_emit_slot, clk, rst_n, !(cmd.emit_resp || cmd.emit_disp) || out_free, "result emitted over a pending word")
    `ASSERT_ALWAYS(a_disp_bound, clk, rst_n, disp_cnt_reg <= mark_cnt_reg, "more dispatches than marked entries")

endmodule

>>> hw/rtl/periodic_task_dispatch_table_core.sv
// Top level of the periodic task dispatch table: sequencer plus datapath.
// Depends on ptdt_pkg, ptdt_ctrl and ptdt_dp.
//
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    tuser: action; tdata: task_id, start_delay, period
// m_*       out  m_tvalid/m_tready    tuser: kind; tdata: task_id_res; tlast: last
// cfg_*     in   cfg_wr_en            cfg_wr_data: tick_prescale
//
// A word is taken only while idle. A tick that does not fire ends at decode; set and
// delete read and compare each entry searched, then respond, a delete first moving
// the tail into the freed slot. A firing tick reads and marks each entry, then reads
// each slot, moving the tail over removed entries, and ends at the last dispatch.
// Reset clears count and m_tvalid and presets prescaler; entry memory is not cleared.
// A stalled m_tready holds the sequencer at its next result and with it the input.
module periodic_task_dispatch_table_core #(
    parameter int TABLE_ENTRIES = ptdt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: tick_prescale
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] task_id, [23:8] start_delay, [39:24] repeat_period
    input  logic [1:0]  s_tuser,   // [1:0] action
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] task_id_res
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast
);

    ptdt_pkg::cmd_t    cmd;
    ptdt_pkg::status_t status;

    // Sequencer: decode, search, mark and dispatch passes
    ptdt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Entry memory, counters, prescaler and result register
    ptdt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
